// ===== src/pfx_pkg.sv =====
// Shared types, character codes and helper functions for the postfix evaluator.
// Used by pfx_alu and postfix_expression_evaluator; depends on nothing.
`default_nettype none

package pfx_pkg;

  localparam int DATA_W = 32;
  localparam int SYM_W  = 8;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_UNDERFLOW,
    ERR_OVERFLOW,
    ERR_DIVZERO
  } err_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  localparam sym_t SYM_ZERO  = 8'h30;
  localparam sym_t SYM_NINE  = 8'h39;
  localparam sym_t SYM_PLUS  = 8'h2B;
  localparam sym_t SYM_MINUS = 8'h2D;
  localparam sym_t SYM_STAR  = 8'h2A;
  localparam sym_t SYM_SLASH = 8'h2F;

  localparam word_t EMPTY_POP = '1;

  function automatic logic is_digit(input sym_t sym);
    return sym inside {[SYM_ZERO:SYM_NINE]};
  endfunction

  function automatic logic is_arith(input sym_t sym);
    return sym inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH};
  endfunction

  function automatic alu_op_t sym_to_op(input sym_t sym);
    alu_op_t op;
    case (sym)
      SYM_MINUS: op = ALU_SUB;
      SYM_STAR:  op = ALU_MUL;
      SYM_SLASH: op = ALU_DIV;
      default:   op = ALU_ADD;
    endcase
    return op;
  endfunction

  // Keeps the first error of an expression.
  function automatic err_t note_error(input err_t cur, input err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

`default_nettype wire

// ===== src/pfx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the operand stack; depends on nothing.
`default_nettype none

module pfx_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/pfx_alu.sv =====
// Shared arithmetic unit: one adder serves add, subtract, shift-add multiply
// and restoring divide at one bit per cycle. Depends on pfx_pkg.
`default_nettype none

module pfx_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfx_pkg::alu_req_t req,
  input  wire pfx_pkg::word_t    op_a,
  input  wire pfx_pkg::word_t    op_b,
  output pfx_pkg::alu_rsp_t      rsp,
  output pfx_pkg::word_t         result
);
  import pfx_pkg::*;

  localparam int STEPS = DATA_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r, busy_nxt;
  alu_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            acc_r, acc_nxt;
  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  logic             neg_r, neg_nxt;
  word_t            res_r, res_nxt;
  logic             done_r, done_nxt;
  logic             dz_r, dz_nxt;

  logic [DATA_W+1:0] add_a, add_b, sum;
  logic              cin;
  word_t             mag_a, mag_b;

  assign mag_a = op_a[DATA_W-1] ? (word_t'(0) - op_a) : op_a;
  assign mag_b = op_b[DATA_W-1] ? (word_t'(0) - op_b) : op_b;

  always_comb begin
    if (!busy_r) begin
      add_a = {2'b00, op_a};
      add_b = (req.op == ALU_SUB) ? {2'b11, ~op_b} : {2'b00, op_b};
      cin   = (req.op == ALU_SUB);
    end else if (op_r == ALU_MUL) begin
      add_a = {2'b00, acc_r};
      add_b = {2'b00, x_r};
      cin   = 1'b0;
    end else begin
      add_a = {1'b0, acc_r, x_r[DATA_W-1]};
      add_b = ~{2'b00, y_r};
      cin   = 1'b1;
    end
    sum = add_a + add_b + {{(DATA_W+1){1'b0}}, cin};
  end

  always_comb begin
    logic  qbit;
    word_t quo;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    dz_nxt   = dz_r;
    done_nxt = 1'b0;
    qbit     = ~sum[DATA_W+1];
    quo      = {x_r[DATA_W-2:0], qbit};
    if (!busy_r) begin
      if (req.start) begin
        op_nxt  = req.op;
        dz_nxt  = 1'b0;
        acc_nxt = '0;
        cnt_nxt = '0;
        case (req.op)
          ALU_ADD, ALU_SUB: begin
            res_nxt  = sum[DATA_W-1:0];
            done_nxt = 1'b1;
          end
          ALU_MUL: begin
            x_nxt    = op_a;
            y_nxt    = op_b;
            busy_nxt = 1'b1;
          end
          ALU_DIV: begin
            if (op_b == '0) begin
              res_nxt  = '0;
              dz_nxt   = 1'b1;
              done_nxt = 1'b1;
            end else begin
              x_nxt    = mag_a;
              y_nxt    = mag_b;
              neg_nxt  = op_a[DATA_W-1] ^ op_b[DATA_W-1];
              busy_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
      case (op_r)
        ALU_MUL: begin
          if (y_r[0]) begin
            acc_nxt = sum[DATA_W-1:0];
          end
          x_nxt   = x_r << 1;
          y_nxt   = y_r >> 1;
          res_nxt = y_r[0] ? sum[DATA_W-1:0] : acc_r;
        end
        ALU_DIV: begin
          acc_nxt = qbit ? sum[DATA_W-1:0] : {acc_r[DATA_W-2:0], x_r[DATA_W-1]};
          x_nxt   = quo;
          res_nxt = neg_r ? (word_t'(0) - quo) : quo;
        end
        default: ;
      endcase
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.div_zero = dz_r;
  assign result       = res_r;

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("Operation started while the unit is busy.");

  a_done_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("Done lasted more than one cycle.");

  a_divzero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dz_r) |-> (res_r == '0 && op_r == ALU_DIV))
    else $error("Divide by zero did not give a zero quotient.");

endmodule

`default_nettype wire

// ===== src/postfix_expression_evaluator.sv =====
// Top level of the postfix evaluator: sequencer, operand stack and result register.
// Depends on pfx_pkg, pfx_ram and pfx_alu.
`default_nettype none

// Each input word is one character of a postfix expression; in_last marks the final
// character, and only that word produces a result word (value and first error status).
// Words are taken one at a time. A digit is pushed onto the stack. An operator pops
// the right and then the left operand. For + - * / the shared adder computes a result,
// working one bit per cycle for * and / unless dividing by zero, and it is pushed;
// any other character only discards two operands. A pop that finds the stack empty
// skips the RAM read, gives all ones and records an underflow. A word with in_last set
// then reads the final value and loads the result register, waiting while an earlier
// result word still waits at the output. The stack RAM needs no clearing after reset.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_symbol,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic        [1:0]       out_status
);
  import pfx_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_R,
    S_GET_R,
    S_POP_L,
    S_GET_L,
    S_EXEC,
    S_WAIT,
    S_PUSH,
    S_FIN_POP,
    S_FIN_GET,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  sym_t          sym_r, sym_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  err_t          err_r, err_nxt;
  word_t         rhs_r, rhs_nxt;
  word_t         lhs_r, lhs_nxt;
  word_t         push_r, push_nxt;
  word_t         top_r, top_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_value_r, out_value_nxt;
  err_t          out_status_r, out_status_nxt;

  logic          ram_we;
  logic [CW-1:0] rd_idx;
  word_t         ram_rdata;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  word_t         alu_result;
  logic          out_free;

  assign rd_idx   = cnt_r - CW'(1);
  assign out_free = !out_valid_r || out_ready;

  pfx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (push_r),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign alu_req.start = (state_r == S_EXEC) && is_arith(sym_r);
  assign alu_req.op    = sym_to_op(sym_r);

  pfx_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .op_a   (lhs_r),
    .op_b   (rhs_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    rhs_nxt        = rhs_r;
    lhs_nxt        = lhs_r;
    push_nxt       = push_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt  = in_symbol;
          last_nxt = in_last;
          if (is_digit(in_symbol)) begin
            push_nxt  = word_t'(in_symbol - SYM_ZERO);
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_POP_R;
          end
        end
      end
      S_POP_R: begin
        if (cnt_r == '0) begin
          rhs_nxt   = EMPTY_POP;
          err_nxt   = note_error(err_r, ERR_UNDERFLOW);
          state_nxt = S_POP_L;
        end else begin
          cnt_nxt   = rd_idx;
          state_nxt = S_GET_R;
        end
      end
      S_GET_R: begin
        rhs_nxt   = ram_rdata;
        state_nxt = S_POP_L;
      end
      S_POP_L: begin
        if (cnt_r == '0) begin
          lhs_nxt   = EMPTY_POP;
          err_nxt   = note_error(err_r, ERR_UNDERFLOW);
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt   = rd_idx;
          state_nxt = S_GET_L;
        end
      end
      S_GET_L: begin
        lhs_nxt   = ram_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (is_arith(sym_r)) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = last_r ? S_FIN_POP : S_IDLE;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          push_nxt = alu_result;
          if (alu_rsp.div_zero) begin
            err_nxt = note_error(err_r, ERR_DIVZERO);
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (cnt_r == CW'(STACK_DEPTH)) begin
          err_nxt = note_error(err_r, ERR_OVERFLOW);
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = last_r ? S_FIN_POP : S_IDLE;
      end
      S_FIN_POP: begin
        if (cnt_r == '0) begin
          top_nxt   = EMPTY_POP;
          err_nxt   = note_error(err_r, ERR_UNDERFLOW);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FIN_GET;
        end
      end
      S_FIN_GET: begin
        top_nxt   = ram_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = top_r;
          out_status_nxt = err_r;
          cnt_nxt        = '0;
          err_nxt        = ERR_NONE;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    rhs_r        <= rhs_nxt;
    lhs_r        <= lhs_nxt;
    push_r       <= push_nxt;
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("Stack count beyond the stack depth.");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cnt_r < CW'(STACK_DEPTH)))
    else $error("Stack written while full.");

  a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_WAIT))
    else $error("Arithmetic result arrived outside the wait state.");

  a_result_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=>
      (out_valid_r && cnt_r == '0 && err_r == ERR_NONE && state_r == S_IDLE))
    else $error("Result word loaded without emptying the stack.");

endmodule

`default_nettype wire
